[rtl/ditfl_pkg.sv]
// Shared types, constants and index arithmetic for the direct index table.
package ditfl_pkg;

    localparam int MODULUS       = 13;
    localparam int INDEX_ENTRIES = 104;
    localparam int DATA_SLOTS    = 64;
    localparam int ROWS          = INDEX_ENTRIES / MODULUS;
    localparam int KEY_LIMIT     = ROWS * MODULUS;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 64;
    localparam int SLOT_W  = 6;
    localparam int POS_W   = 7;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;

    typedef logic [ACT_W-1:0]   action_t;
    typedef logic [STAT_W-1:0]  status_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [KEY_W-1:0]   key_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_LOOKUP = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;
    localparam action_t ACT_NOP    = 2'd3;

    localparam status_t STAT_OK        = 3'd0;
    localparam status_t STAT_EXISTS    = 3'd1;
    localparam status_t STAT_NOT_FOUND = 3'd2;
    localparam status_t STAT_FULL      = 3'd3;
    localparam status_t STAT_RANGE     = 3'd4;

    // Reciprocal of the modulus scaled by 2**10; exact for every key below the limit.
    localparam logic [6:0] RECIP_13 = 7'd79;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INDEX,
        ST_VALUE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_index;
        logic rd_value;
        logic commit;
    } dp_cmd_t;

    // Index entry for an in-range key: (key mod 13) * 8 + key div 13.
    function automatic pos_t key_to_pos(input logic [6:0] k);
        logic [13:0] prod;
        logic [2:0]  quot;
        logic [6:0]  rem;
        prod = k * RECIP_13;
        quot = prod[12:10];
        rem  = k - ({4'b0000, quot} * 7'd13);
        return {rem[3:0], quot};
    endfunction

endpackage

[rtl/ditfl_ctrl.sv]
// Sequencing state machine for the direct index table.
module ditfl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output ditfl_pkg::dp_cmd_t cmd
);

    ditfl_pkg::state_t state_reg;
    ditfl_pkg::state_t state_next;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ditfl_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.commit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ditfl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ditfl_pkg::ST_INDEX;
                end
            end
            ditfl_pkg::ST_INDEX:
            begin
                cmd.rd_index = 1'b1;
                state_next   = ditfl_pkg::ST_VALUE;
            end
            ditfl_pkg::ST_VALUE:
            begin
                cmd.rd_value = 1'b1;
                state_next   = ditfl_pkg::ST_COMMIT;
            end
            ditfl_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ditfl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ditfl_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ditfl_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

[rtl/ditfl_dpath.sv]
// Index, slot and free-list storage with the request decision logic.
module ditfl_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  ditfl_pkg::dp_cmd_t  cmd,
    input  ditfl_pkg::action_t  action,
    input  ditfl_pkg::key_t     key,
    input  ditfl_pkg::value_t   value,
    output ditfl_pkg::status_t  status,
    output ditfl_pkg::value_t   value_out,
    output ditfl_pkg::slot_t    slot
);

    // Storage.
    logic [ditfl_pkg::INDEX_ENTRIES-1:0] used_reg;
    ditfl_pkg::slot_t  entry_slot_mem [ditfl_pkg::INDEX_ENTRIES];
    ditfl_pkg::value_t slot_value_mem [ditfl_pkg::DATA_SLOTS];
    ditfl_pkg::slot_t  link_mem       [ditfl_pkg::DATA_SLOTS];
    logic [ditfl_pkg::DATA_SLOTS-1:0]    link_valid_reg;
    ditfl_pkg::slot_t  free_head_reg;

    // Captured request.
    ditfl_pkg::action_t act_reg;
    ditfl_pkg::value_t  val_in_reg;
    ditfl_pkg::pos_t    pos_reg;
    logic               range_bad_reg;

    // Read results.
    logic               used_rd_reg;
    ditfl_pkg::slot_t   es_rd_reg;
    ditfl_pkg::slot_t   link_rd_reg;
    ditfl_pkg::slot_t   link_mem_rd;
    ditfl_pkg::value_t  val_rd_reg;

    // Result registers.
    ditfl_pkg::status_t status_reg;
    ditfl_pkg::value_t  value_out_reg;
    ditfl_pkg::slot_t   slot_reg;

    // Commit decisions.
    ditfl_pkg::status_t status_next;
    ditfl_pkg::value_t  value_out_next;
    ditfl_pkg::slot_t   slot_next;
    logic               do_insert;
    logic               do_delete;
    logic               key_ok;

    assign key_ok = (key < ditfl_pkg::KEY_W'(ditfl_pkg::KEY_LIMIT));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg       <= action;
            val_in_reg    <= value;
            range_bad_reg <= !key_ok;
            pos_reg       <= key_ok ? ditfl_pkg::key_to_pos(key[6:0]) : '0;
        end
        if (cmd.rd_index)
        begin
            used_rd_reg <= used_reg[pos_reg];
            es_rd_reg   <= entry_slot_mem[pos_reg];
            link_mem_rd <= link_mem[free_head_reg];
        end
        if (cmd.rd_value)
        begin
            val_rd_reg  <= slot_value_mem[es_rd_reg];
            // A link never written is read as its reset chain value, the next slot number.
            link_rd_reg <= link_valid_reg[free_head_reg] ? link_mem_rd
                                                         : free_head_reg + 1'b1;
        end
        if (do_insert)
        begin
            slot_value_mem[free_head_reg] <= val_in_reg;
            entry_slot_mem[pos_reg]       <= free_head_reg;
        end
        if (do_delete)
        begin
            link_mem[es_rd_reg] <= free_head_reg;
        end
        if (cmd.commit)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            link_valid_reg <= '0;
            free_head_reg  <= ditfl_pkg::SLOT_W'(1);
        end
        else
        begin
            if (do_insert)
            begin
                used_reg[pos_reg] <= 1'b1;
                free_head_reg     <= link_rd_reg;
            end
            if (do_delete)
            begin
                used_reg[pos_reg]         <= 1'b0;
                link_valid_reg[es_rd_reg] <= 1'b1;
                free_head_reg             <= es_rd_reg;
            end
        end
    end

    always_comb
    begin
        status_next    = ditfl_pkg::STAT_OK;
        value_out_next = '0;
        slot_next      = '0;
        do_insert      = 1'b0;
        do_delete      = 1'b0;
        priority if (act_reg == ditfl_pkg::ACT_NOP)
        begin
            status_next = ditfl_pkg::STAT_OK;
        end
        else if (range_bad_reg)
        begin
            status_next = ditfl_pkg::STAT_RANGE;
        end
        else if (act_reg == ditfl_pkg::ACT_INSERT)
        begin
            if (used_rd_reg)
            begin
                status_next = ditfl_pkg::STAT_EXISTS;
            end
            else if (free_head_reg == '0)
            begin
                status_next = ditfl_pkg::STAT_FULL;
            end
            else
            begin
                slot_next = free_head_reg;
                do_insert = cmd.commit;
            end
        end
        else if (!used_rd_reg)
        begin
            status_next = ditfl_pkg::STAT_NOT_FOUND;
        end
        else
        begin
            value_out_next = val_rd_reg;
            slot_next      = es_rd_reg;
            do_delete      = cmd.commit && (act_reg == ditfl_pkg::ACT_DELETE);
        end
    end

    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign slot      = slot_reg;

endmodule

[rtl/direct_index_table_with_free_list.sv]
// Top level of the keyed record store with direct index and free-list allocator.
//
// A request is presented on action, key and value together with start, and is
// taken at the rising edge where start is high and busy is low. Insert stores
// value in the slot at the head of the free list and binds the key's index
// entry to it; lookup returns the stored value; delete returns it, frees the
// index entry and pushes the slot back on the free list. The index entry of a
// key is (key mod 13) * 8 + key div 13; keys of 104 and above are rejected.
// Each request produces exactly one result on status, value_out and slot,
// shown for one cycle with done high. The receiver cannot hold results off.
// Sequence: index read, slot data read, commit, then the registered result.
// busy stays high from the taken request until its commit, so a new request
// is not taken before the previous one has committed; this order comes from
// the chain of registered memory reads, where the data slot address is known
// only after the index entry has been read.
// Reset clears every index entry, restores the free list to slots one through
// sixty-three in order and puts its head at slot one; no clearing pass is needed.
module direct_index_table_with_free_list
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ditfl_pkg::action_t  action,
    input  ditfl_pkg::key_t     key,
    input  ditfl_pkg::value_t   value,
    output logic                done,
    output ditfl_pkg::status_t  status,
    output ditfl_pkg::value_t   value_out,
    output ditfl_pkg::slot_t    slot
);

    // Command bundle from the sequencer to the storage and decision logic.
    ditfl_pkg::dp_cmd_t cmd;

    // The sequencer only moves through its four steps once a request is taken.
    ditfl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // All storage, the free list and the result registers live in the datapath.
    ditfl_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (action),
        .key       (key),
        .value     (value),
        .status    (status),
        .value_out (value_out),
        .slot      (slot)
    );

endmodule
